### src/loose_date_text_recognizer_unit_defines.svh
// ----------------------------------------------------------------------------
// Loose date text recognizer - assertion macros
// Shorthand for clocked implication checks with reset masking.
// ----------------------------------------------------------------------------
`ifndef LOOSE_DATE_TEXT_RECOGNIZER_UNIT_DEFINES_SVH
`define LOOSE_DATE_TEXT_RECOGNIZER_UNIT_DEFINES_SVH

// same-cycle implication
`define LDTR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ldtr: same-cycle check failed");

// next-cycle implication
`define LDTR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ldtr: next-cycle check failed");

`endif

### src/ldtr_pkg.sv
// ----------------------------------------------------------------------------
// Loose date text recognizer - package
// Field state, result types and the run-closing decision shared by the RTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ldtr_pkg;

	localparam int MAX_DIGIT_RUN = 19;

	localparam logic [4:0] RUN_MAX  = 5'(MAX_DIGIT_RUN);
	localparam logic [4:0] RUN_TWO  = 5'd2;
	localparam logic [4:0] RUN_YEAR = 5'd4;
	localparam logic [4:0] RUN_YM   = 5'd6;

	localparam logic [3:0] CNT_YM  = 4'd6;
	localparam logic [3:0] CNT_YDM = 4'd7;
	localparam logic [3:0] CNT_US  = 4'd10;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef enum logic [1:0] {
		PH_RUN1,
		PH_MON,
		PH_DAY,
		PH_YEAR
	} phase_t;

	typedef enum logic [1:0] {
		V_OPEN,
		V_MATCH,
		V_FAIL
	} verdict_t;

	typedef struct packed {
		phase_t      phase;
		logic [4:0]  run_cnt;
		logic [13:0] acc_hi;
		logic [6:0]  acc_lo;
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [7:0]  delim;
		logic [3:0]  cnt;
		verdict_t    verdict;
	} fld_state_t;

	typedef struct packed {
		logic        matched;
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [7:0]  consumed;
	} res_t;

	localparam fld_state_t FLD_RESET = '{
		phase:   PH_RUN1,
		run_cnt: 5'd0,
		acc_hi:  14'd0,
		acc_lo:  7'd0,
		year:    14'd0,
		month:   7'd0,
		day:     7'd1,
		delim:   8'd0,
		cnt:     4'd0,
		verdict: V_OPEN
	};

	function automatic fld_state_t end_run(input fld_state_t s, input logic [7:0] t,
			input logic at_end, input logic us);
		fld_state_t r;
		r = s;
		unique case (s.phase)
			PH_RUN1: begin
				if (s.run_cnt == RUN_YM) begin
					r.year    = s.acc_hi;
					r.month   = s.acc_lo;
					r.cnt     = CNT_YM;
					r.verdict = V_MATCH;
				end else if (!at_end && s.run_cnt == RUN_YEAR) begin
					r.year    = s.acc_hi;
					r.delim   = t;
					r.phase   = PH_MON;
					r.run_cnt = 5'd0;
					r.acc_hi  = 14'd0;
					r.acc_lo  = 7'd0;
				end else if (!at_end && s.run_cnt == RUN_TWO && us) begin
					r.month   = s.acc_hi[6:0];
					r.delim   = t;
					r.phase   = PH_DAY;
					r.run_cnt = 5'd0;
					r.acc_hi  = 14'd0;
					r.acc_lo  = 7'd0;
				end else begin
					r.verdict = V_FAIL;
				end
			end
			PH_MON: begin
				if (s.run_cnt == RUN_TWO && (at_end || t != s.delim)) begin
					r.month   = s.acc_hi[6:0];
					r.cnt     = CNT_YDM;
					r.verdict = V_MATCH;
				end else begin
					r.verdict = V_FAIL;
				end
			end
			PH_DAY: begin
				if (!at_end && s.run_cnt == RUN_TWO && t == s.delim) begin
					r.day     = s.acc_hi[6:0];
					r.phase   = PH_YEAR;
					r.run_cnt = 5'd0;
					r.acc_hi  = 14'd0;
					r.acc_lo  = 7'd0;
				end else begin
					r.verdict = V_FAIL;
				end
			end
			default: begin
				if (s.run_cnt == RUN_YEAR) begin
					r.year    = s.acc_hi;
					r.cnt     = CNT_US;
					r.verdict = V_MATCH;
				end else begin
					r.verdict = V_FAIL;
				end
			end
		endcase
		return r;
	endfunction

endpackage

### src/ldtr_step.sv
// ----------------------------------------------------------------------------
// Loose date text recognizer - character step
// Next field state and result for one character beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ldtr_step (
	input  ldtr_pkg::fld_state_t cur,
	input  logic [7:0]           ch,
	input  logic                 last,
	input  logic                 us_style,
	output ldtr_pkg::fld_state_t nxt,
	output ldtr_pkg::res_t       res
);
	import ldtr_pkg::*;

	fld_state_t s_a;
	fld_state_t s_b;
	logic       is_digit;
	logic [3:0] dval;

	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign dval     = ch[3:0];

	always_comb begin
		s_a = cur;
		if (cur.verdict == V_OPEN) begin
			if (is_digit && cur.run_cnt < RUN_MAX) begin
				if (cur.run_cnt < RUN_YEAR) begin
					s_a.acc_hi = (cur.acc_hi << 3) + (cur.acc_hi << 1) + {10'd0, dval};
				end else if (cur.run_cnt < RUN_YM) begin
					s_a.acc_lo = (cur.acc_lo << 3) + (cur.acc_lo << 1) + {3'd0, dval};
				end
				s_a.run_cnt = cur.run_cnt + 5'd1;
			end else begin
				s_a = end_run(cur, ch, 1'b0, us_style);
			end
		end
	end

	always_comb begin
		s_b = s_a;
		if (last && s_a.verdict == V_OPEN) begin
			s_b = end_run(s_a, 8'h00, 1'b1, us_style);
		end
	end

	always_comb begin
		res = '0;
		if (s_b.verdict == V_MATCH) begin
			res.matched  = 1'b1;
			res.year     = s_b.year;
			res.month    = s_b.month;
			res.day      = s_b.day;
			res.consumed = {4'd0, s_b.cnt};
		end
		nxt = last ? FLD_RESET : s_b;
	end

endmodule

### src/loose_date_text_recognizer_unit.sv
// Last beat of a field: input register, then result register, which raises out_valid.
// Throughput: one character beat per cycle unless in_stall; one result beat per field.
// A last beat waits in the input stage only while the result register is full
// and stalled.
// Reset: arst_n clears the field state, us_style and both valid flags at once.
// ----------------------------------------------------------------------------
// Loose date text recognizer - top level
// Input register, field state register and result register around the step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module loose_date_text_recognizer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  ch,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        matched,
	output logic [13:0] year,
	output logic [6:0]  month,
	output logic [6:0]  day,
	output logic [7:0]  consumed
);
	import ldtr_pkg::*;

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       last_s1;
	logic       us_style_q;
	fld_state_t fld_q;
	fld_state_t fld_nxt;
	res_t       res_nxt;
	res_t       res_q;
	logic       out_valid_q;
	logic       out_free;
	logic       take_s1;

	assign out_free = !out_valid_q || !out_stall;
	assign take_s1  = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			us_style_q <= 1'b0;
		end else if (cfg_we) begin
			us_style_q <= cfg_wdata;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	ldtr_step u_step (
		.cur      (fld_q),
		.ch       (ch_s1),
		.last     (last_s1),
		.us_style (us_style_q),
		.nxt      (fld_nxt),
		.res      (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fld_q <= FLD_RESET;
		end else if (take_s1) begin
			fld_q <= fld_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && last_s1) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = res_q.matched;
	assign year      = res_q.year;
	assign month     = res_q.month;
	assign day       = res_q.day;
	assign consumed  = res_q.consumed;

endmodule

### src/ldtr_checker.sv
// ----------------------------------------------------------------------------
// Loose date text recognizer - port checker
// Result beat consistency and output hold seen at the top-level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "loose_date_text_recognizer_unit_defines.svh"

module ldtr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        matched,
	input logic [13:0] year,
	input logic [6:0]  month,
	input logic [6:0]  day,
	input logic [7:0]  consumed
);

	`LDTR_ASSERT_NOW(a_nomatch_zero, out_valid && !matched, {year, month, day, consumed} == '0)
	`LDTR_ASSERT_NOW(a_consumed_form, out_valid && matched, consumed == 8'd6 || consumed == 8'd7 || consumed == 8'd10)
	`LDTR_ASSERT_NOW(a_day_default, out_valid && matched && consumed < 8'd8, day == 7'd1)
	`LDTR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

endmodule

bind loose_date_text_recognizer_unit ldtr_checker u_ldtr_checker (.*);

### tb/tb_loose_date_text_recognizer_unit.sv
// ----------------------------------------------------------------------------
// Loose date text recognizer - testbench
// Streams text fields one character beat at a time, with us_style switched
// between phases, and compares every result beat against a cycle-free
// predictor of the date forms. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_loose_date_text_recognizer_unit;

	import ldtr_pkg::*;

	class date_field_tracker;
		bit          us_mode;
		phase_t      ph;
		verdict_t    vd;
		logic [4:0]  run_len;
		logic [19:0] acc;
		logic [13:0] yr;
		logic [6:0]  mon;
		logic [6:0]  dy;
		logic [7:0]  delim;
		logic [7:0]  used;
		res_t        due_dates[$];
		int          mismatch_count;

		function new();
			us_mode = 1'b0;
			mismatch_count = 0;
			clear_field();
		endfunction

		function void clear_field();
			ph      = PH_RUN1;
			vd      = V_OPEN;
			run_len = '0;
			acc     = '0;
			yr      = '0;
			mon     = '0;
			dy      = 7'd1;
			delim   = '0;
			used    = '0;
		endfunction

		function void close_run(logic [7:0] t, bit at_end);
			case (ph)
				PH_RUN1: begin
					if (run_len == RUN_YM) begin
						yr   = 14'(acc / 100);
						mon  = 7'(acc % 100);
						used = 8'd6;
						vd   = V_MATCH;
					end else if (!at_end && run_len == RUN_YEAR) begin
						yr      = 14'(acc);
						delim   = t;
						ph      = PH_MON;
						run_len = '0;
						acc     = '0;
					end else if (!at_end && run_len == RUN_TWO && us_mode) begin
						mon     = 7'(acc);
						delim   = t;
						ph      = PH_DAY;
						run_len = '0;
						acc     = '0;
					end else begin
						vd = V_FAIL;
					end
				end
				PH_MON: begin
					if (run_len == RUN_TWO && (at_end || t != delim)) begin
						mon  = 7'(acc);
						used = 8'd7;
						vd   = V_MATCH;
					end else begin
						vd = V_FAIL;
					end
				end
				PH_DAY: begin
					if (!at_end && run_len == RUN_TWO && t == delim) begin
						dy      = 7'(acc);
						ph      = PH_YEAR;
						run_len = '0;
						acc     = '0;
					end else begin
						vd = V_FAIL;
					end
				end
				default: begin
					if (run_len == RUN_YEAR) begin
						yr   = 14'(acc);
						used = 8'd10;
						vd   = V_MATCH;
					end else begin
						vd = V_FAIL;
					end
				end
			endcase
		endfunction

		function void note_char(logic [7:0] c, logic lst);
			res_t r;
			if (vd == V_OPEN) begin
				if (c >= CH_ZERO && c <= CH_NINE && run_len < RUN_MAX) begin
					if (run_len < RUN_YM)
						acc = 20'(acc * 10 + 20'(c - CH_ZERO));
					run_len = run_len + 5'd1;
				end else begin
					close_run(c, 1'b0);
				end
			end
			if (lst) begin
				if (vd == V_OPEN)
					close_run(8'h00, 1'b1);
				r = '0;
				if (vd == V_MATCH) begin
					r.matched  = 1'b1;
					r.year     = yr;
					r.month    = mon;
					r.day      = dy;
					r.consumed = used;
				end
				due_dates.push_back(r);
				clear_field();
			end
		endfunction

		function void check_result(res_t got);
			res_t exp;
			if (due_dates.size() == 0) begin
				$error("result beat with no field pending");
				mismatch_count++;
				return;
			end
			exp = due_dates.pop_front();
			if (got.matched !== exp.matched) begin
				$error("matched: expected %0d, got %0d", exp.matched, got.matched);
				mismatch_count++;
			end
			if (got.year !== exp.year) begin
				$error("year: expected %0d, got %0d", exp.year, got.year);
				mismatch_count++;
			end
			if (got.month !== exp.month) begin
				$error("month: expected %0d, got %0d", exp.month, got.month);
				mismatch_count++;
			end
			if (got.day !== exp.day) begin
				$error("day: expected %0d, got %0d", exp.day, got.day);
				mismatch_count++;
			end
			if (got.consumed !== exp.consumed) begin
				$error("consumed: expected %0d, got %0d", exp.consumed, got.consumed);
				mismatch_count++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  ch;
	logic        last;
	logic        out_valid;
	logic        out_stall;
	logic        matched;
	logic [13:0] year;
	logic [6:0]  month;
	logic [6:0]  day;
	logic [7:0]  consumed;

	date_field_tracker tracker = new();
	logic [7:0] field_q[$];
	int         burst_left = 0;
	bit         idle_on = 1'b1;
	int         chars_sent = 0;
	int         stall_mode = 0;
	int         stall_left = 0;

	loose_date_text_recognizer_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.ch        (ch),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.matched   (matched),
		.year      (year),
		.month     (month),
		.day       (day),
		.consumed  (consumed)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(16, 96);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= 1'($urandom_range(0, 1));
			2: out_stall <= ($urandom_range(0, 7) != 0);
			default: out_stall <= (stall_left % 4 == 0);
		endcase
	end

	always @(negedge clk) begin
		res_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.matched  = matched;
			got.year     = year;
			got.month    = month;
			got.day      = day;
			got.consumed = consumed;
			tracker.check_result(got);
		end
	end

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_delim();
		logic [7:0] d;
		d = 8'($urandom_range(0, 255));
		while (d >= CH_ZERO && d <= CH_NINE)
			d = 8'($urandom_range(0, 255));
		return d;
	endfunction

	function automatic void add_digits(int n);
		for (int i = 0; i < n; i++)
			field_q.push_back(rand_digit());
	endfunction

	function automatic void load_text(string s);
		field_q.delete();
		for (int i = 0; i < s.len(); i++)
			field_q.push_back(s[i]);
	endfunction

	function automatic void make_field();
		int         kind;
		int         n;
		logic [7:0] d;
		kind = $urandom_range(0, 9);
		field_q.delete();
		d = rand_delim();
		case (kind)
			0, 1: add_digits(6);
			2, 3: begin
				add_digits(4);
				field_q.push_back(d);
				add_digits(2);
			end
			4, 5, 8, 9: begin
				if (kind == 8 || kind == 9) begin
					case ($urandom_range(0, 2))
						0: add_digits(6);
						1: begin
							add_digits(4);
							field_q.push_back(d);
							add_digits(2);
						end
						default: ;
					endcase
				end
				if (field_q.size() == 0) begin
					add_digits(2);
					field_q.push_back(d);
					add_digits(2);
					field_q.push_back(($urandom_range(0, 4) == 0) ? rand_delim() : d);
					add_digits(4);
				end
			end
			6: begin
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++) begin
					add_digits($urandom_range(1, 25));
					if (i < n - 1)
						field_q.push_back(rand_delim());
				end
			end
			default: begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++)
					field_q.push_back(8'($urandom_range(0, 255)));
			end
		endcase
		if (kind == 8 || kind == 9) begin
			n = $urandom_range(1, field_q.size());
			while (field_q.size() > n)
				void'(field_q.pop_back());
		end else if (kind <= 5) begin
			case ($urandom_range(0, 4))
				1: begin
					field_q.push_back(d);
					add_digits($urandom_range(0, 3));
				end
				2: begin
					n = $urandom_range(1, 4);
					for (int i = 0; i < n; i++)
						field_q.push_back(8'($urandom_range(0, 255)));
				end
				3: add_digits(1);
				default: ;
			endcase
		end
		if ($urandom_range(0, 7) == 0)
			field_q[$urandom_range(0, field_q.size() - 1)] = 8'($urandom_range(0, 255));
	endfunction

	task automatic drive_beat(input logic [7:0] b, input logic l);
		int gap;
		bit stalled;
		if (burst_left == 0) begin
			burst_left = idle_on ? $urandom_range(1, 12) : 1000;
			if (idle_on) begin
				in_valid <= 1'b0;
				gap = $urandom_range(1, 5);
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		ch       <= b;
		last     <= l;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		tracker.note_char(b, l);
		burst_left--;
		chars_sent++;
	endtask

	task automatic send_field();
		for (int i = 0; i < field_q.size(); i++)
			drive_beat(field_q[i], i == field_q.size() - 1);
	endtask

	// hold the sender until every pending result has drained
	task automatic drain();
		in_valid   <= 1'b0;
		burst_left = 0;
		while (tracker.due_dates.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_style(input bit v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		tracker.us_mode = v;
	endtask

	initial begin
		bit style_seq[6];
		bit idle_seq[6];
		style_seq = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
		idle_seq  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= 1'b0;
		in_valid  <= 1'b0;
		ch        <= 8'h00;
		last      <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_style(1'b0);
		load_text("999912");
		send_field();
		load_text("0000\37799");
		send_field();
		field_q = '{8'h00};
		send_field();
		drain();
		write_style(1'b1);
		load_text("12/31/9999");
		send_field();

		for (int p = 0; p < 6; p++) begin
			drain();
			write_style(style_seq[p]);
			idle_on = idle_seq[p];
			while (chars_sent < 24 + 85 * (p + 1)) begin
				make_field();
				send_field();
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (tracker.mismatch_count == 0 && tracker.due_dates.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
